// ===== hw/rtl/stg_pkg.sv =====
// Shared types, constants and the sine table generator of the tone generator.
// No dependencies; every other file of the block but stg_stream_if imports it.
package stg_pkg;

  localparam int SINE_TABLE_BITS_DEFAULT = 10;
  localparam int PHASE_BITS_DEFAULT      = 32;
  localparam int SAMPLE_BITS             = 16;
  localparam int GATE_BITS               = 24;
  localparam int CFG_INDEX_BITS          = 3;
  localparam int CFG_DATA_BITS           = 32;
  localparam int FULL_SCALE              = 32767;
  localparam int TONE_LIMIT              = FULL_SCALE * 4096;
  localparam int AM_CLAMP_LEVEL          = FULL_SCALE * 32768;
  localparam int AM_BIAS                 = 2 * FULL_SCALE;

  localparam longint unsigned PI_Q30 = 64'd3373259426;
  localparam longint unsigned TAYLOR_DIV [8] = '{
    64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210, 64'd272
  };

  typedef enum logic [1:0] {
    MODE_REPLACE = 2'd0,
    MODE_ADD     = 2'd1,
    MODE_AM      = 2'd2
  } mode_t;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_CARRIER_STEP   = 3'd0,
    REG_MODULATOR_STEP = 3'd1,
    REG_GAIN           = 3'd2,
    REG_OFFSET         = 3'd3,
    REG_MODE           = 3'd4,
    REG_GATE_OFF_COUNT = 3'd5,
    REG_GATE_ON_COUNT  = 3'd6
  } cfg_reg_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL_CARRIER,
    S_MUL_MOD,
    S_DIVIDE,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] existing_sample;
    logic                          last_in_buffer;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample_out;
    logic                          end_of_buffer;
  } out_item_t;

  typedef struct packed {
    logic                          we;
    logic [CFG_INDEX_BITS-1:0]     index;
    logic [CFG_DATA_BITS-1:0]      data;
  } cfg_write_t;

  typedef struct packed {
    logic [31:0]                   carrier_step;
    logic [31:0]                   modulator_step;
    logic signed [SAMPLE_BITS-1:0] gain;
    logic signed [SAMPLE_BITS-1:0] offset;
    mode_t                         mode;
    logic [GATE_BITS-1:0]          gate_off_count;
    logic [GATE_BITS-1:0]          gate_on_count;
  } cfg_t;

  typedef struct packed {
    logic load_in;
    logic rom_mod;
    logic mul_gain;
    logic mul_mod;
    logic est_div;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic out_busy;
  } status_t;

  // Q1.15 sine value for entry k of a table of 2^bits entries, built at elaboration
  function automatic logic [SAMPLE_BITS-1:0] sine_entry(int unsigned k, int unsigned bits);
    longint unsigned half;
    longint unsigned quarter;
    longint unsigned m;
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint          sum;
    longint          r;
    half    = 64'd1 << (bits - 1);
    quarter = 64'd1 << (bits - 2);
    m       = longint'(k) & (half - 64'd1);
    if (m > quarter) begin
      m = half - m;
    end
    x    = (64'd2 * PI_Q30 * m) >> bits;
    x2   = (x * x) >> 30;
    term = x;
    sum  = longint'(x);
    for (int n = 1; n <= 8; n++) begin
      term = ((term * x2) >> 30) / TAYLOR_DIV[n-1];
      if (n % 2 == 1) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    r = (sum * FULL_SCALE + (64'sd1 <<< 29)) >>> 30;
    if (r > FULL_SCALE) begin
      r = FULL_SCALE;
    end
    if (longint'(k) >= longint'(half)) begin
      r = -r;
    end
    return SAMPLE_BITS'(r);
  endfunction

endpackage

// ===== hw/rtl/stg_stream_if.sv =====
// Valid/ready stream channel carrying one payload item per transfer.
// Payload type is set by the instantiating level; no package dependency.
interface stg_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/stg_sine_rom.sv =====
// Sine lookup ROM with registered read, contents computed at elaboration.
// Depends on stg_pkg for sine_entry.
module stg_sine_rom #(
  parameter int TABLE_BITS = stg_pkg::SINE_TABLE_BITS_DEFAULT
) (
  input  logic                                clk,
  input  logic [TABLE_BITS-1:0]               addr,
  output logic signed [stg_pkg::SAMPLE_BITS-1:0] data
);
  import stg_pkg::*;

  localparam int TABLE_LEN = 1 << TABLE_BITS;

  logic [SAMPLE_BITS-1:0] rom_c [TABLE_LEN];

  for (genvar k = 0; k < TABLE_LEN; k++) begin : g_entry
    assign rom_c[k] = sine_entry(k, TABLE_BITS);
  end

  always_ff @(posedge clk) begin
    data <= $signed(rom_c[addr]);
  end

endmodule

// ===== hw/rtl/stg_cfg_regs.sv =====
// Configuration register file of the tone generator: write decode and reset values.
// Depends on stg_pkg for the register index codes and the cfg_t layout.
module stg_cfg_regs (
  input  logic                clk,
  input  logic                rst,
  input  stg_pkg::cfg_write_t wr,
  output stg_pkg::cfg_t       cfg
);
  import stg_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.carrier_step   <= '0;
      cfg.modulator_step <= '0;
      cfg.gain           <= SAMPLE_BITS'(4096);
      cfg.offset         <= '0;
      cfg.mode           <= MODE_REPLACE;
      cfg.gate_off_count <= '0;
      cfg.gate_on_count  <= '0;
    end else if (wr.we) begin
      unique case (cfg_reg_t'(wr.index))
        REG_CARRIER_STEP:   cfg.carrier_step   <= wr.data[31:0];
        REG_MODULATOR_STEP: cfg.modulator_step <= wr.data[31:0];
        REG_GAIN:           cfg.gain           <= $signed(wr.data[SAMPLE_BITS-1:0]);
        REG_OFFSET:         cfg.offset         <= $signed(wr.data[SAMPLE_BITS-1:0]);
        REG_MODE:           cfg.mode           <= mode_t'(wr.data[1:0]);
        REG_GATE_OFF_COUNT: cfg.gate_off_count <= wr.data[GATE_BITS-1:0];
        REG_GATE_ON_COUNT:  cfg.gate_on_count  <= wr.data[GATE_BITS-1:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== hw/rtl/stg_datapath.sv =====
// Datapath: phase accumulators, sine ROM, gain and modulator multiply steps, AM divide,
// gate counter and output register. Depends on stg_pkg and stg_sine_rom.
module stg_datapath #(
  parameter int SINE_TABLE_BITS = stg_pkg::SINE_TABLE_BITS_DEFAULT,
  parameter int PHASE_BITS      = stg_pkg::PHASE_BITS_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  stg_pkg::cfg_t      cfg,
  input  stg_pkg::cmd_t      cmd,
  output stg_pkg::status_t   status,
  input  stg_pkg::in_item_t  in_data,
  input  logic               out_ready,
  output logic               out_valid,
  output stg_pkg::out_item_t out_data
);
  import stg_pkg::*;

  logic [PHASE_BITS-1:0]         carrier_phase;
  logic [PHASE_BITS-1:0]         modulator_phase;
  logic [GATE_BITS-1:0]          gate_count;
  logic                          gate_passing;
  logic signed [SAMPLE_BITS-1:0] existing;
  logic                          last;

  logic [SINE_TABLE_BITS-1:0]    rom_addr;
  logic signed [SAMPLE_BITS-1:0] rom_q;

  logic signed [31:0]            prod1;
  logic signed [49:0]            prod2;
  logic signed [SAMPLE_BITS-1:0] tone_res;
  logic                          am_neg;
  logic                          am_big;
  logic [29:0]                   am_b;
  logic [16:0]                   am_q0;

  // tone path
  logic signed [32:0]            offset_term;
  logic signed [32:0]            tone_acc;
  logic signed [32:0]            tone_clamped;
  logic signed [32:0]            tone_biased;
  logic signed [SAMPLE_BITS-1:0] tone;
  logic signed [17:0]            mod_factor;

  // AM divide path
  logic [49:0]                   am_mag;
  logic [36:0]                   am_shift;
  logic [29:0]                   am_low;
  logic [30:0]                   am_r;
  logic [16:0]                   am_q;
  logic [SAMPLE_BITS-1:0]        am_mag_res;
  logic signed [SAMPLE_BITS-1:0] am_res;

  // finish step
  logic signed [SAMPLE_BITS-1:0] sample;
  logic signed [SAMPLE_BITS-1:0] gated;
  logic [GATE_BITS-1:0]          gate_count_next;
  logic                          gate_passing_next;

  assign rom_addr = cmd.rom_mod ? modulator_phase[PHASE_BITS-1 -: SINE_TABLE_BITS]
                                : carrier_phase[PHASE_BITS-1 -: SINE_TABLE_BITS];

  stg_sine_rom #(
    .TABLE_BITS (SINE_TABLE_BITS)
  ) u_rom (
    .clk  (clk),
    .addr (rom_addr),
    .data (rom_q)
  );

  always_comb begin
    offset_term = (33'(cfg.offset) <<< 15) - 33'(cfg.offset);
    tone_acc    = 33'(prod1) + offset_term;
    if (tone_acc > 33'(TONE_LIMIT)) begin
      tone_clamped = 33'(TONE_LIMIT);
    end else if (tone_acc < -33'(TONE_LIMIT)) begin
      tone_clamped = -33'(TONE_LIMIT);
    end else begin
      tone_clamped = tone_acc;
    end
    tone_biased = tone_clamped[32] ? tone_clamped + 33'sd4095 : tone_clamped;
    tone        = SAMPLE_BITS'(tone_biased >>> 12);
    mod_factor  = 18'(AM_BIAS) + 18'(rom_q);
  end

  always_comb begin
    am_mag   = prod2[49] ? 50'(-prod2) : 50'(prod2);
    am_shift = am_mag[49:13];
    am_low   = am_shift[29:0];
    am_r       = 31'(am_b) - ((31'(am_q0) << 15) - 31'(am_q0));
    am_q       = am_q0 + 17'(am_r >= 31'(FULL_SCALE));
    am_mag_res = am_big ? SAMPLE_BITS'(FULL_SCALE) : am_q[SAMPLE_BITS-1:0];
    am_res     = am_neg ? -$signed(am_mag_res) : $signed(am_mag_res);
  end

  always_comb begin
    case (cfg.mode)
      MODE_AM: sample = am_res;
      default: sample = tone_res;
    endcase
    gated             = sample;
    gate_count_next   = gate_count;
    gate_passing_next = gate_passing;
    if (cfg.gate_off_count != '0) begin
      if (!gate_passing_next && gate_count_next >= cfg.gate_off_count) begin
        gate_passing_next = 1'b1;
        gate_count_next   = '0;
      end
      if (gate_passing_next && gate_count_next >= cfg.gate_on_count) begin
        gate_passing_next = 1'b0;
        gate_count_next   = '0;
      end
      if (!gate_passing_next) begin
        gated = '0;
      end
      gate_count_next = gate_count_next + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      existing <= in_data.existing_sample;
      last     <= in_data.last_in_buffer;
    end
    if (cmd.mul_gain) begin
      prod1 <= 32'(cfg.gain) * 32'(rom_q);
    end
    if (cmd.mul_mod) begin
      prod2 <= 50'(prod1) * 50'(mod_factor);
      if (cfg.mode == MODE_ADD) begin
        tone_res <= existing + tone;
      end else begin
        tone_res <= tone;
      end
    end
    if (cmd.est_div) begin
      am_neg <= prod2[49];
      am_big <= am_shift >= 37'(AM_CLAMP_LEVEL);
      am_b   <= am_low;
      am_q0  <= 17'((31'(am_low) + 31'(am_low >> 15)) >> 15);
    end
    if (cmd.finish) begin
      out_data.sample_out    <= gated;
      out_data.end_of_buffer <= last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      carrier_phase   <= '0;
      modulator_phase <= '0;
      gate_count      <= '0;
      gate_passing    <= 1'b0;
      out_valid       <= 1'b0;
    end else begin
      if (cmd.finish) begin
        out_valid <= 1'b1;
        if (last) begin
          carrier_phase   <= '0;
          modulator_phase <= '0;
          gate_count      <= '0;
          gate_passing    <= 1'b0;
        end else begin
          carrier_phase   <= carrier_phase + PHASE_BITS'(cfg.carrier_step);
          modulator_phase <= modulator_phase + PHASE_BITS'(cfg.modulator_step);
          gate_count      <= gate_count_next;
          gate_passing    <= gate_passing_next;
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign status.out_busy = out_valid && !out_ready;

endmodule

// ===== hw/rtl/stg_controller.sv =====
// Sequencer of the tone generator: steps one sample through read, multiply,
// divide and finish. Depends on stg_pkg for state, command and status types.
module stg_controller (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  stg_pkg::status_t status,
  output stg_pkg::cmd_t    cmd
);
  import stg_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = S_MUL_CARRIER;
        end
      end
      S_MUL_CARRIER: begin
        cmd.mul_gain = 1'b1;
        cmd.rom_mod  = 1'b1;
        state_next   = S_MUL_MOD;
      end
      S_MUL_MOD: begin
        cmd.mul_mod = 1'b1;
        state_next  = S_DIVIDE;
      end
      S_DIVIDE: begin
        cmd.est_div = 1'b1;
        state_next  = S_FINISH;
      end
      S_FINISH: begin
        if (!status.out_busy) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// ===== hw/rtl/sine_tone_generator.sv =====
// Top level of the sine tone generator: configuration registers, controller
// and datapath. Depends on stg_pkg, stg_stream_if and the stg_* modules.
//
// Usage: samples_in carries one buffer sample per transfer (existing_sample,
// last_in_buffer); samples_out returns exactly one sample per input transfer,
// in order, with end_of_buffer copied from last_in_buffer. The configuration
// port writes register cfg_index with cfg_data whenever cfg_we is high; write
// only while no sample is in flight. Indexes beyond the register list are
// ignored.
// Sequencing: the sequencer takes an input only while idle and walks each
// sample through the carrier read, the gain multiply, the modulator multiply,
// the reciprocal divide estimate and the finish step, which registers the
// result in the output register; the next input is taken after that step.
// Both sine reads share the single-port sine ROM.
// Reset: phases, gate counter and output valid clear; registers take their
// reset values (gain 1.0, all else zero).
// Stall: a finished sample waits in the output register; the next input can
// be taken meanwhile, and the finish step holds until the output slot frees.
module sine_tone_generator #(
  parameter int SINE_TABLE_BITS = stg_pkg::SINE_TABLE_BITS_DEFAULT,
  parameter int PHASE_BITS      = stg_pkg::PHASE_BITS_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [stg_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [stg_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  stg_stream_if.sink                         samples_in,
  stg_stream_if.source                       samples_out
);
  import stg_pkg::*;

  cfg_write_t cfg_wr;
  cfg_t       cfg;
  cmd_t       cmd;
  status_t    status;
  in_item_t   in_item;
  out_item_t  out_item;
  logic       in_ready;
  logic       out_valid;

  assign cfg_wr.we    = cfg_we;
  assign cfg_wr.index = cfg_index;
  assign cfg_wr.data  = cfg_data;

  assign in_item.existing_sample = samples_in.data.existing_sample;
  assign in_item.last_in_buffer  = samples_in.data.last_in_buffer;
  assign samples_in.ready        = in_ready;

  assign samples_out.valid                = out_valid;
  assign samples_out.data.sample_out      = out_item.sample_out;
  assign samples_out.data.end_of_buffer   = out_item.end_of_buffer;

  stg_cfg_regs u_cfg (
    .clk (clk),
    .rst (rst),
    .wr  (cfg_wr),
    .cfg (cfg)
  );

  stg_controller u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (samples_in.valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  stg_datapath #(
    .SINE_TABLE_BITS (SINE_TABLE_BITS),
    .PHASE_BITS      (PHASE_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cmd       (cmd),
    .status    (status),
    .in_data   (in_item),
    .out_ready (samples_out.ready),
    .out_valid (out_valid),
    .out_data  (out_item)
  );

endmodule

// ===== tb/sine_tone_generator_tb.sv =====
// Self-checking testbench of sine_tone_generator: directed and random sample traffic
// under random stalls, checked against a scoreboard holding its own tone predictor.
// Depends on stg_pkg, stg_stream_if and the sine_tone_generator RTL.
`timescale 1ns / 100ps

module sine_tone_generator_tb;
  import stg_pkg::*;

  localparam int TB_LUT_BITS    = SINE_TABLE_BITS_DEFAULT;
  localparam int TB_PHASE_BITS  = PHASE_BITS_DEFAULT;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam logic [CFG_INDEX_BITS-1:0] REG_UNUSED = 3'd7;

  typedef struct packed {
    logic [31:0]          carrier_step;
    logic [31:0]          modulator_step;
    logic [15:0]          gain;
    logic [15:0]          offset;
    logic [1:0]           mode;
    logic [GATE_BITS-1:0] gate_off;
    logic [GATE_BITS-1:0] gate_on;
  } tone_setting_t;

  class tone_scoreboard;
    logic signed [15:0]       sine_lut [1 << TB_LUT_BITS];
    logic [31:0]              carrier_step;
    logic [31:0]              modulator_step;
    logic signed [15:0]       gain;
    logic signed [15:0]       offset;
    logic [1:0]               mode;
    logic [GATE_BITS-1:0]     gate_off;
    logic [GATE_BITS-1:0]     gate_on;
    logic [TB_PHASE_BITS-1:0] carrier_phase;
    logic [TB_PHASE_BITS-1:0] modulator_phase;
    logic [GATE_BITS-1:0]     gate_count;
    logic                     gate_passing;
    out_item_t                expected_samples [$];
    int                       failures;
    int                       checked;

    function new();
      longint unsigned half;
      longint unsigned quarter;
      longint unsigned m;
      int              v;
      half    = 64'd1 << (TB_LUT_BITS - 1);
      quarter = 64'd1 << (TB_LUT_BITS - 2);
      for (int k = 0; k < (1 << TB_LUT_BITS); k++) begin
        m = longint'(k) & (half - 64'd1);
        if (m > quarter) begin
          m = half - m;
        end
        v = quarter_wave(m);
        sine_lut[k] = (k >= half) ? 16'(-v) : 16'(v);
      end
      carrier_step    = '0;
      modulator_step  = '0;
      gain            = 16'sd4096;
      offset          = '0;
      mode            = MODE_REPLACE;
      gate_off        = '0;
      gate_on         = '0;
      carrier_phase   = '0;
      modulator_phase = '0;
      gate_count      = '0;
      gate_passing    = 1'b0;
      failures        = 0;
      checked         = 0;
    endfunction

    // Taylor series of sine on the first quadrant in Q30, scaled to Q1.15
    function int quarter_wave(longint unsigned m);
      longint unsigned x;
      longint unsigned x2;
      longint unsigned term;
      longint unsigned div;
      longint          sum;
      longint          r;
      x    = (64'd2 * PI_Q30 * m) >> TB_LUT_BITS;
      x2   = (x * x) >> 30;
      term = x;
      sum  = longint'(x);
      for (int n = 1; n <= 8; n++) begin
        div  = (2 * n) * (2 * n + 1);
        term = ((term * x2) >> 30) / div;
        if (n % 2 == 1) begin
          sum = sum - longint'(term);
        end else begin
          sum = sum + longint'(term);
        end
      end
      if (sum < 0) begin
        sum = 0;
      end
      r = (sum * FULL_SCALE + (longint'(1) << 29)) >>> 30;
      if (r > FULL_SCALE) begin
        r = FULL_SCALE;
      end
      return int'(r);
    endfunction

    function void write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
      case (idx)
        REG_CARRIER_STEP:   carrier_step   = data;
        REG_MODULATOR_STEP: modulator_step = data;
        REG_GAIN:           gain           = data[15:0];
        REG_OFFSET:         offset         = data[15:0];
        REG_MODE:           mode           = data[1:0];
        REG_GATE_OFF_COUNT: gate_off       = data[GATE_BITS-1:0];
        REG_GATE_ON_COUNT:  gate_on        = data[GATE_BITS-1:0];
        default: ;
      endcase
    endfunction

    function logic [15:0] predict_tone(in_item_t it);
      logic signed [15:0] sc;
      logic signed [15:0] sm;
      logic [15:0]        res;
      longint             acc;
      longint             lim;
      int                 tone;
      sc  = sine_lut[carrier_phase >> (TB_PHASE_BITS - TB_LUT_BITS)];
      lim = longint'(FULL_SCALE) * 4096;
      if (mode == MODE_AM) begin
        sm  = sine_lut[modulator_phase >> (TB_PHASE_BITS - TB_LUT_BITS)];
        acc = longint'(gain) * longint'(sc) * (longint'(65534) + longint'(sm));
        acc = acc / (longint'(8192) * FULL_SCALE);
        if (acc > FULL_SCALE) begin
          acc = FULL_SCALE;
        end
        if (acc < -FULL_SCALE) begin
          acc = -FULL_SCALE;
        end
        res = 16'(acc);
      end else begin
        acc = longint'(gain) * longint'(sc) + longint'(offset) * FULL_SCALE;
        if (acc > lim) begin
          acc = lim;
        end
        if (acc < -lim) begin
          acc = -lim;
        end
        tone = int'(acc / 4096);
        if (mode == MODE_ADD) begin
          res = it.existing_sample + 16'(tone);
        end else begin
          res = 16'(tone);
        end
      end
      if (gate_off != 0) begin
        if (!gate_passing && gate_count >= gate_off) begin
          gate_passing = 1'b1;
          gate_count   = '0;
        end
        if (gate_passing && gate_count >= gate_on) begin
          gate_passing = 1'b0;
          gate_count   = '0;
        end
        if (!gate_passing) begin
          res = '0;
        end
        gate_count = gate_count + 1'b1;
      end
      if (it.last_in_buffer) begin
        carrier_phase   = '0;
        modulator_phase = '0;
        gate_count      = '0;
        gate_passing    = 1'b0;
      end else begin
        carrier_phase   = carrier_phase + carrier_step;
        modulator_phase = modulator_phase + modulator_step;
      end
      return res;
    endfunction

    function void note_input(in_item_t it);
      out_item_t want;
      want.sample_out    = predict_tone(it);
      want.end_of_buffer = it.last_in_buffer;
      expected_samples.push_back(want);
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      checked++;
      if (expected_samples.size() == 0) begin
        $error("sample_out: expected none, got %0d", got.sample_out);
        failures++;
        return;
      end
      want = expected_samples.pop_front();
      if (got.sample_out !== want.sample_out) begin
        $error("sample_out: expected %0d, got %0d", want.sample_out, got.sample_out);
        failures++;
      end
      if (got.end_of_buffer !== want.end_of_buffer) begin
        $error("end_of_buffer: expected %0b, got %0b", want.end_of_buffer, got.end_of_buffer);
        failures++;
      end
    endfunction

    function int pending();
      return expected_samples.size();
    endfunction
  endclass

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      cfg_we;
  logic [CFG_INDEX_BITS-1:0] cfg_index;
  logic [CFG_DATA_BITS-1:0]  cfg_data;
  logic                      steady = 1'b0;
  int                        idle_cycles = 0;
  int                        items_sent = 0;
  int                        settings_applied = 0;
  tone_scoreboard            sb = new();

  stg_stream_if #(.payload_t(in_item_t))  in_ch ();
  stg_stream_if #(.payload_t(out_item_t)) out_ch ();

  sine_tone_generator dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .samples_in  (in_ch),
    .samples_out (out_ch)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_we) begin
        sb.write_reg(cfg_index, cfg_data);
      end
      if (in_ch.valid && in_ch.ready) begin
        sb.note_input(in_ch.data);
      end
      if (out_ch.valid && out_ch.ready) begin
        sb.check_result(out_ch.data);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || cfg_we) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (steady || roll < 55) begin
      return 0;
    end
    if (roll < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(10, 40);
  endfunction

  // Output side: hold ready for a while, then stall
  initial begin
    int stall;
    forever begin
      out_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      stall = pick_gap();
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
    end
  end

  function automatic logic [15:0] pick_sample();
    int roll;
    roll = $urandom_range(0, 99);
    case (roll % 8)
      0: if (roll < 16) return 16'h7FFF;
      1: if (roll < 16) return 16'h8000;
      2: if (roll < 16) return 16'h0000;
      3: if (roll < 16) return 16'hFFFF;
      default: ;
    endcase
    return 16'($urandom());
  endfunction

  function automatic logic [31:0] pick_step();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 5) begin
      return 32'h0000_0000;
    end
    if (roll < 10) begin
      return 32'hFFFF_FFFF;
    end
    if (roll < 15) begin
      return 32'h8000_0000;
    end
    if (roll < 55) begin
      return $urandom_range(0, 1 << 26);
    end
    return $urandom();
  endfunction

  function automatic logic [15:0] pick_q412(int zero_pct);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < zero_pct) begin
      return 16'h0000;
    end
    if (roll < zero_pct + 6) begin
      return 16'h7FFF;
    end
    if (roll < zero_pct + 12) begin
      return 16'h8000;
    end
    if (roll < zero_pct + 20) begin
      return 16'h1000;
    end
    return 16'($urandom());
  endfunction

  function automatic tone_setting_t random_setting();
    tone_setting_t s;
    int            roll;
    s.carrier_step   = pick_step();
    s.modulator_step = pick_step();
    s.gain           = pick_q412(3);
    s.offset         = pick_q412(45);
    s.mode           = 2'($urandom_range(0, 3));
    roll             = $urandom_range(0, 99);
    if (roll < 35) begin
      s.gate_off = '0;
      s.gate_on  = GATE_BITS'($urandom());
    end else if (roll < 90) begin
      s.gate_off = GATE_BITS'($urandom_range(1, 12));
      s.gate_on  = GATE_BITS'($urandom_range(0, 12));
    end else begin
      s.gate_off = GATE_BITS'($urandom());
      s.gate_on  = GATE_BITS'($urandom());
    end
    return s;
  endfunction

  function automatic tone_setting_t make_setting(logic [31:0] cstep, logic [31:0] mstep,
                                                 logic [15:0] g, logic [15:0] ofs,
                                                 logic [1:0] md, logic [GATE_BITS-1:0] off,
                                                 logic [GATE_BITS-1:0] on);
    tone_setting_t s;
    s.carrier_step   = cstep;
    s.modulator_step = mstep;
    s.gain           = g;
    s.offset         = ofs;
    s.mode           = md;
    s.gate_off       = off;
    s.gate_on        = on;
    return s;
  endfunction

  // Write every register back to back, plus one index past the list
  task automatic apply_setting(input tone_setting_t s);
    logic [31:0] junk;
    logic [CFG_INDEX_BITS-1:0] idx [8];
    logic [31:0] val [8];
    junk   = $urandom();
    idx[0] = REG_CARRIER_STEP;   val[0] = s.carrier_step;
    idx[1] = REG_MODULATOR_STEP; val[1] = s.modulator_step;
    idx[2] = REG_GAIN;           val[2] = {junk[31:16], s.gain};
    idx[3] = REG_OFFSET;         val[3] = {junk[15:0], s.offset};
    idx[4] = REG_MODE;           val[4] = {junk[31:2], s.mode};
    idx[5] = REG_GATE_OFF_COUNT; val[5] = {junk[31:24], s.gate_off};
    idx[6] = REG_GATE_ON_COUNT;  val[6] = {junk[7:0], s.gate_on};
    idx[7] = REG_UNUSED;         val[7] = $urandom();
    for (int i = 0; i < 8; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= val[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    settings_applied++;
  endtask

  // Valid stays high after a transfer; the next call drops it only before a gap, settle always drops it
  task automatic send_sample(input logic [15:0] smp, input logic last);
    in_item_t it;
    int       gap;
    it.existing_sample = smp;
    it.last_in_buffer  = last;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= it;
    do @(posedge clk); while (!in_ch.ready);
    items_sent++;
  endtask

  // Drop valid and wait until every expected sample has come back
  task automatic settle();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic send_series(input int n, input int last_at);
    for (int i = 0; i < n; i++) begin
      send_sample((i % 2) ? 16'h8000 : 16'h7FFF, i == last_at);
    end
    settle();
  endtask

  task automatic run_traffic(input int n, input int max_len);
    int left_in_buf;
    left_in_buf = $urandom_range(1, max_len);
    for (int i = 0; i < n; i++) begin
      left_in_buf--;
      send_sample(pick_sample(), left_in_buf == 0);
      if (left_in_buf == 0) begin
        left_in_buf = $urandom_range(1, max_len);
      end
      if ($urandom_range(0, 199) == 0) begin
        settle();
      end
    end
    settle();
  endtask

  initial begin
    in_ch.valid <= 1'b0;
    in_ch.data  <= '0;
    cfg_we      <= 1'b0;
    cfg_index   <= '0;
    cfg_data    <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: reset values, clamps, mode three, wrap in add mode, AM extremes, gate cases
    send_series(2, 1);
    apply_setting(make_setting(32'h4000_0000, 32'h0, 16'h7FFF, 16'h7FFF, MODE_REPLACE,
                               24'h0, 24'h0));
    send_series(2, -1);
    apply_setting(make_setting(32'h4000_0000, 32'h0, 16'h8000, 16'h8000, 2'd3,
                               24'h0, 24'h0));
    send_series(2, 1);
    apply_setting(make_setting(32'h4000_0000, 32'h0, 16'h1000, 16'h0000, MODE_ADD,
                               24'h0, 24'h0));
    send_series(4, 3);
    apply_setting(make_setting(32'h4000_0000, 32'hC000_0000, 16'h8000, 16'h0, MODE_AM,
                               24'h0, 24'h0));
    send_series(4, 3);
    apply_setting(make_setting(32'h0100_0000, 32'h0, 16'h1000, 16'h0, MODE_REPLACE,
                               24'd2, 24'd0));
    send_series(3, -1);
    apply_setting(make_setting(32'h0100_0000, 32'h0, 16'h1000, 16'h0, MODE_REPLACE,
                               24'd1, 24'd2));
    send_series(6, 3);
    apply_setting(make_setting(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'h7FFF, 16'h7FFF, MODE_AM,
                               24'h0, 24'hFFFFFF));
    send_series(2, -1);

    // Random phases, the extreme settings first
    for (int p = 0; p < 16; p++) begin
      tone_setting_t s;
      if (p == 0) begin
        s = make_setting(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'h7FFF, 16'h7FFF, 2'd3,
                         24'hFFFFFF, 24'hFFFFFF);
      end else if (p == 1) begin
        s = make_setting(32'h0, 32'h0, 16'h8000, 16'h8000, MODE_REPLACE, 24'h0, 24'h0);
      end else begin
        s = random_setting();
      end
      steady = ($urandom_range(0, 3) == 0);
      apply_setting(s);
      run_traffic(100, (p % 2) ? 200 : 8);
    end
    steady = 1'b0;

    repeat (20) @(posedge clk);
    $display("tb: %0d samples sent, %0d checked, %0d register settings, %0d mismatches",
             items_sent, sb.checked, settings_applied, sb.failures);
    $display("tb: covered replace, add, AM and mode three with clamps, gate runs and restarts");
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/stg_pkg.sv
hw/rtl/stg_stream_if.sv
hw/rtl/stg_sine_rom.sv
hw/rtl/stg_cfg_regs.sv
hw/rtl/stg_datapath.sv
hw/rtl/stg_controller.sv
hw/rtl/sine_tone_generator.sv
tb/sine_tone_generator_tb.sv
